@@ rtl/core/srec_lc_pkg.sv @@
// Shared types and constants for the S-record line checker.
// Holds the beat structs, status codes and character constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package srec_lc_pkg;

  localparam int SLC_MAX_LINE_CHARS = 1023;

  // Status codes reported at each line end.
  typedef logic [2:0] status_t;
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ODD_LENGTH = 3'd1;
  localparam status_t ST_BAD_TYPE   = 3'd2;
  localparam status_t ST_NON_HEX    = 3'd3;
  localparam status_t ST_BYTE_COUNT = 3'd4;
  localparam status_t ST_CHECKSUM   = 3'd5;
  localparam status_t ST_NO_HEADER  = 3'd6;
  localparam status_t ST_BAD_SECOND = 3'd7;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_FOUR = 8'h34;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_F    = 8'h46;

  localparam logic [3:0] TYPE_UNREADABLE = 4'hF;
  localparam logic [3:0] TYPE_MAX_DIGIT  = 4'd9;
  localparam logic [7:0] SUM_OK          = 8'hFF;
  localparam logic [7:0] MIN_COUNT       = 8'd3;
  localparam int         LEN_S5_S9       = 10;
  localparam int         LEN_S6_S8       = 12;
  localparam int         LEN_S7          = 14;
  localparam logic [5:0] ADDR_BITS_BASE  = 6'd8;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       file_start;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] record_type;
    logic [5:0] data_addr_bits;
  } out_beat_t;

  // Line summary after the current character, handed to the judge.
  typedef struct packed {
    logic [1:0] line_index;
    logic [3:0] type_digit;
    logic       type_bad;
    logic       hex_bad;
    logic [7:0] count_field;
    logic [7:0] byte_sum;
  } line_info_t;

endpackage

`default_nettype wire

@@ rtl/core/srec_lc_track.sv @@
// Per-line tracking state of the S-record checker: position, type, sum.
// Updates once per stepped character; shows the post-update line summary.
// Depends on srec_lc_pkg.
`default_nettype none

module srec_lc_track #(
  parameter int MAX_LINE_CHARS = srec_lc_pkg::SLC_MAX_LINE_CHARS,
  parameter int POS_W          = $clog2(MAX_LINE_CHARS + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step,
  input  wire srec_lc_pkg::in_beat_t  beat,
  output logic [POS_W-1:0]            len,
  output srec_lc_pkg::line_info_t     info
);
  import srec_lc_pkg::*;

  logic [POS_W-1:0] char_pos;
  logic [3:0]       high_nibble;
  logic [7:0]       byte_sum;
  logic [7:0]       count_field;
  logic [3:0]       type_digit;
  logic             type_bad;
  logic             hex_bad;
  logic [1:0]       line_index;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_upd;
  logic [1:0]       idx;
  logic [3:0]       high_nibble_next;
  logic [7:0]       byte_sum_next;
  logic [7:0]       count_field_next;
  logic [3:0]       type_digit_next;
  logic             type_bad_next;
  logic             hex_bad_next;
  logic             is_digit;
  logic             is_hex;
  logic [3:0]       nib;
  logic [7:0]       byte_val;

  always_comb begin
    is_digit = (beat.ch >= CHAR_ZERO) && (beat.ch <= CHAR_NINE);
    is_hex   = is_digit || ((beat.ch >= CHAR_A) && (beat.ch <= CHAR_F));
    if (is_digit) begin
      nib = beat.ch[3:0];
    end else if (is_hex) begin
      nib = beat.ch[3:0] + 4'd9;
    end else begin
      nib = 4'd0;
    end
  end

  always_comb begin
    pos              = beat.file_start ? '0 : char_pos;
    idx              = beat.file_start ? 2'd0 : line_index;
    pos_upd          = pos;
    high_nibble_next = high_nibble;
    byte_sum_next    = byte_sum;
    count_field_next = count_field;
    type_digit_next  = type_digit;
    type_bad_next    = type_bad;
    hex_bad_next     = hex_bad;
    byte_val         = {high_nibble, nib};
    // Characters past the length limit are dropped unchecked.
    if (pos < POS_W'(MAX_LINE_CHARS)) begin
      pos_upd = pos + POS_W'(1);
      if (pos == '0) begin
        byte_sum_next    = '0;
        hex_bad_next     = 1'b0;
        count_field_next = '0;
        high_nibble_next = '0;
        type_digit_next  = '0;
        type_bad_next    = (beat.ch != CHAR_S);
      end else if (pos == POS_W'(1)) begin
        if (is_digit) begin
          type_digit_next = beat.ch[3:0];
          if (beat.ch == CHAR_FOUR) begin
            type_bad_next = 1'b1;
          end
        end else begin
          type_digit_next = TYPE_UNREADABLE;
          type_bad_next   = 1'b1;
        end
      end else begin
        if (!is_hex) begin
          hex_bad_next = 1'b1;
        end
        if (!pos[0]) begin
          high_nibble_next = nib;
        end else begin
          byte_sum_next = byte_sum + byte_val;
          if (pos == POS_W'(3)) begin
            count_field_next = byte_val;
          end
        end
      end
    end
  end

  assign len                = pos_upd;
  assign info.line_index    = idx;
  assign info.type_digit    = type_digit_next;
  assign info.type_bad      = type_bad_next;
  assign info.hex_bad       = hex_bad_next;
  assign info.count_field   = count_field_next;
  assign info.byte_sum      = byte_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos    <= '0;
      high_nibble <= '0;
      byte_sum    <= '0;
      count_field <= '0;
      type_digit  <= '0;
      type_bad    <= 1'b0;
      hex_bad     <= 1'b0;
      line_index  <= '0;
    end else if (step) begin
      high_nibble <= high_nibble_next;
      byte_sum    <= byte_sum_next;
      count_field <= count_field_next;
      type_digit  <= type_digit_next;
      type_bad    <= type_bad_next;
      hex_bad     <= hex_bad_next;
      if (beat.line_end) begin
        char_pos   <= '0;
        line_index <= (idx == 2'd2) ? idx : idx + 2'd1;
      end else begin
        char_pos   <= pos_upd;
        line_index <= idx;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srec_lc_judge.sv @@
// Line verdict of the S-record checker: status, type and address width.
// Purely combinational, from the line summary and length.
// Depends on srec_lc_pkg.
`default_nettype none

module srec_lc_judge #(
  parameter int POS_W = 10
) (
  input  wire logic [POS_W-1:0]       len,
  input  wire srec_lc_pkg::line_info_t info,
  output srec_lc_pkg::out_beat_t      verdict
);
  import srec_lc_pkg::*;

  logic             readable;
  logic [POS_W-1:0] half_body;
  logic [3:0]       td;
  status_t          status;
  logic [5:0]       addr_bits;

  always_comb begin
    td        = info.type_digit;
    readable  = (len >= POS_W'(2)) && (td <= TYPE_MAX_DIGIT);
    half_body = (len - POS_W'(4)) >> 1;

    if (info.line_index == 2'd0 && !(readable && td == 4'd0 && !info.type_bad)) begin
      status = ST_NO_HEADER;
    end else if (info.line_index == 2'd1 && readable && (td == 4'd0 || td >= 4'd5)) begin
      status = ST_BAD_SECOND;
    end else if (len[0]) begin
      status = ST_ODD_LENGTH;
    end else if (info.type_bad) begin
      status = ST_BAD_TYPE;
    end else if (info.hex_bad) begin
      status = ST_NON_HEX;
    end else if (len < POS_W'(4) || info.count_field < MIN_COUNT
                 || half_body != POS_W'(info.count_field)) begin
      status = ST_BYTE_COUNT;
    end else if ((td == 4'd5 || td == 4'd9) && len != POS_W'(LEN_S5_S9)) begin
      status = ST_BYTE_COUNT;
    end else if ((td == 4'd6 || td == 4'd8) && len != POS_W'(LEN_S6_S8)) begin
      status = ST_BYTE_COUNT;
    end else if (td == 4'd7 && len != POS_W'(LEN_S7)) begin
      status = ST_BYTE_COUNT;
    end else if (info.byte_sum != SUM_OK) begin
      status = ST_CHECKSUM;
    end else begin
      status = ST_OK;
    end

    // Data lines S1, S2, S3 carry 16, 24 or 32 address bits.
    if (info.line_index == 2'd1 && readable && !info.type_bad
        && td >= 4'd1 && td <= 4'd3) begin
      addr_bits = {td[2:0], 3'b000} + ADDR_BITS_BASE;
    end else begin
      addr_bits = '0;
    end
  end

  assign verdict.status         = status;
  assign verdict.record_type    = readable ? td : 4'd0;
  assign verdict.data_addr_bits = addr_bits;

endmodule

`default_nettype wire

@@ rtl/core/srec_line_checker_top.sv @@
// Top level of the S-record line checker: input register, tracker, judge
// and result register. Depends on srec_lc_pkg, srec_lc_track, srec_lc_judge.
//
// Usage:
// The character channel (char_valid, char_stall, char_beat) carries one
// character of S-record text per beat, with a flag for the last character
// of a line and a flag for the first character of a file. The result
// channel (result_valid, result_stall, result_beat) carries one verdict per
// line: a status code, the record type digit and, for the second line of a
// file, the data address width.
// A character beat is captured into an input register, then processed against
// the per-line state once the result register is free or being emptied; a
// line-end character loads the result register. A line's verdict thus passes
// through the input register and the result register before it is offered.
// One character is taken every cycle while the receiver does not stall.
// Reset clears the line state, the line count and both registers; the first
// line after reset counts as line one of a file.
// When the receiver stalls, the result register holds its beat and the input
// register keeps its character, so char_stall rises while both are full and
// no character is dropped. Lines longer than MAX_LINE_CHARS are judged on
// their first MAX_LINE_CHARS characters.
`default_nettype none

module srec_line_checker_top #(
  parameter int MAX_LINE_CHARS = srec_lc_pkg::SLC_MAX_LINE_CHARS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    char_valid,
  output logic                         char_stall,
  input  wire srec_lc_pkg::in_beat_t   char_beat,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output srec_lc_pkg::out_beat_t       result_beat
);
  import srec_lc_pkg::*;

  localparam int POS_W = $clog2(MAX_LINE_CHARS + 1);

  logic             held_valid;
  in_beat_t         held_beat;
  logic             advance;
  logic             step;
  logic [POS_W-1:0] len;
  line_info_t       info;
  out_beat_t        verdict;

  // The held character moves on whenever the result register is free or
  // being emptied in this cycle.
  assign advance    = !result_valid || !result_stall;
  assign step       = held_valid && advance;
  assign char_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!char_stall) begin
      held_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!char_stall && char_valid) begin
      held_beat <= char_beat;
    end
  end

  srec_lc_track #(
    .MAX_LINE_CHARS (MAX_LINE_CHARS),
    .POS_W          (POS_W)
  ) u_track (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .beat (held_beat),
    .len  (len),
    .info (info)
  );

  srec_lc_judge #(
    .POS_W (POS_W)
  ) u_judge (
    .len     (len),
    .info    (info),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && held_beat.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (step && held_beat.line_end) begin
      result_beat <= verdict;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/srec_lc_checker.sv @@
// Port-level checks for the S-record line checker, bound to its top level.
// Depends on srec_lc_pkg and srec_line_checker_top.
`default_nettype none

module srec_lc_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   result_valid,
  input wire logic                   result_stall,
  input wire srec_lc_pkg::out_beat_t result_beat
);
  import srec_lc_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result beat withdrawn while stalled");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_beat))
    else $error("result beat changed while stalled");

  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered right after reset");

  a_addr_matches_type: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.data_addr_bits != 6'd0 |->
      (result_beat.data_addr_bits == 6'd16 && result_beat.record_type == 4'd1) ||
      (result_beat.data_addr_bits == 6'd24 && result_beat.record_type == 4'd2) ||
      (result_beat.data_addr_bits == 6'd32 && result_beat.record_type == 4'd3))
    else $error("address width disagrees with record type");

  a_ok_not_s4: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_beat.status == ST_OK |-> result_beat.record_type != 4'd4)
    else $error("S4 line reported as good");

endmodule

bind srec_line_checker_top srec_lc_checker u_srec_lc_checker (.*);

`default_nettype wire

@@ tb/sv/srec_line_checker_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for srec_line_checker_top: a table of directed lines, then
// random S-record files with corruptions, checked against an in-bench line tracker.
// Depends on srec_lc_pkg and the RTL of the block; reads no files.

module srec_line_checker_top_tb;
  import srec_lc_pkg::*;

  // Record type digits as they appear after the 'S'.
  localparam logic [3:0] REC_HEADER   = 4'd0;
  localparam logic [3:0] REC_DATA16   = 4'd1;
  localparam logic [3:0] REC_DATA24   = 4'd2;
  localparam logic [3:0] REC_DATA32   = 4'd3;
  localparam logic [3:0] REC_COUNT16  = 4'd5;
  localparam logic [3:0] REC_COUNT24  = 4'd6;
  localparam logic [3:0] REC_START32  = 4'd7;
  localparam logic [3:0] REC_START24  = 4'd8;
  localparam logic [3:0] REC_START16  = 4'd9;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_CHARS = 1850;
  localparam int SETTLE       = 20;
  localparam int DRILL_ROWS   = 22;

  // One row of the directed table. Rows with typed set carry the verdict that
  // is expected at a glance; the tracker covers the rest.
  typedef struct packed {
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } drill_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      char_valid = 1'b0;
  logic      char_stall;
  in_beat_t  char_beat = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_beat_t result_beat;

  // Line tracker: the bench's own view of the block's per-line state.
  int         pos_in_line = 0;
  logic [3:0] nib_hi = '0;
  logic [7:0] running_sum = '0;
  logic [7:0] declared_count = '0;
  logic [3:0] type_num = '0;
  logic       type_err = 1'b0;
  logic       digit_err = 1'b0;
  logic [1:0] line_no = '0;

  out_beat_t  verdicts_due[$];
  logic [7:0] line_text[$];
  drill_row_t drill_rows[DRILL_ROWS];
  int         restart_at = -1;
  int         random_chars = 0;
  int         fault_count = 0;
  int         cycle_count = 0;
  int         hold_asks = 0;
  bit         char_gaps = 1'b1;
  bit         result_gaps = 1'b1;

  always #2 clk = ~clk;

  srec_line_checker_top DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_beat    (char_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat)
  );

  // Advances the line tracker by one accepted character. Returns 1 and the
  // verdict when the character closes a line.
  function automatic bit predict_verdict(input in_beat_t b, output out_beat_t v);
    int         len;
    bit         readable;
    logic [7:0] code;
    logic [3:0] nib;
    logic [7:0] pair;
    v = '0;
    if (b.file_start) begin
      line_no = '0;
      pos_in_line = 0;
    end
    // Past the character limit the rest of the line is dropped unchecked.
    if (pos_in_line < SLC_MAX_LINE_CHARS) begin
      if (pos_in_line == 0) begin
        running_sum = '0;
        digit_err = 1'b0;
        declared_count = '0;
        nib_hi = '0;
        type_num = '0;
        type_err = (b.ch != CHAR_S);
      end else if (pos_in_line == 1) begin
        if (b.ch >= CHAR_ZERO && b.ch <= CHAR_NINE) begin
          code = b.ch - CHAR_ZERO;
          type_num = code[3:0];
          if (b.ch == CHAR_FOUR) type_err = 1'b1;
        end else begin
          type_num = TYPE_UNREADABLE;
          type_err = 1'b1;
        end
      end else begin
        // Only 0-9 and upper case A-F are hex; anything else sums as zero.
        if (b.ch >= CHAR_ZERO && b.ch <= CHAR_NINE) begin
          code = b.ch - CHAR_ZERO;
        end else if (b.ch >= CHAR_A && b.ch <= CHAR_F) begin
          code = b.ch - CHAR_A + 8'd10;
        end else begin
          code = '0;
          digit_err = 1'b1;
        end
        nib = code[3:0];
        if (pos_in_line % 2 == 0) begin
          nib_hi = nib;
        end else begin
          pair = {nib_hi, nib};
          running_sum = running_sum + pair;
          if (pos_in_line == 3) declared_count = pair;
        end
      end
      pos_in_line++;
    end
    if (!b.line_end) return 1'b0;

    len = pos_in_line;
    readable = (len >= 2) && (type_num <= TYPE_MAX_DIGIT);
    // The first matching fault wins, header and second-line checks first.
    if (line_no == 2'd0 && !(readable && type_num == REC_HEADER && !type_err))
      v.status = ST_NO_HEADER;
    else if (line_no == 2'd1 && readable && (type_num == REC_HEADER || type_num >= REC_COUNT16))
      v.status = ST_BAD_SECOND;
    else if (len % 2 != 0)
      v.status = ST_ODD_LENGTH;
    else if (type_err)
      v.status = ST_BAD_TYPE;
    else if (digit_err)
      v.status = ST_NON_HEX;
    else if (len < 4 || declared_count < MIN_COUNT || (len - 4) / 2 != declared_count)
      v.status = ST_BYTE_COUNT;
    else if ((type_num == REC_COUNT16 || type_num == REC_START16) && len != LEN_S5_S9)
      v.status = ST_BYTE_COUNT;
    else if ((type_num == REC_COUNT24 || type_num == REC_START24) && len != LEN_S6_S8)
      v.status = ST_BYTE_COUNT;
    else if (type_num == REC_START32 && len != LEN_S7)
      v.status = ST_BYTE_COUNT;
    else if (running_sum != SUM_OK)
      v.status = ST_CHECKSUM;
    else
      v.status = ST_OK;
    v.record_type = readable ? type_num : '0;
    if (line_no == 2'd1 && readable && !type_err && type_num >= REC_DATA16 &&
        type_num <= REC_DATA32)
      v.data_addr_bits = {2'b00, type_num} * 6'd8 + ADDR_BITS_BASE;
    pos_in_line = 0;
    if (line_no < 2'd2) line_no++;
    return 1'b1;
  endfunction

  function automatic drill_row_t drill_row(input logic [7:0] ch, input logic last,
                                           input logic opens, input logic typed,
                                           input status_t st, input logic [3:0] rec,
                                           input logic [5:0] bits);
    drill_row_t r;
    r.beat.ch = ch;
    r.beat.line_end = last;
    r.beat.file_start = opens;
    r.typed = typed;
    r.want.status = st;
    r.want.record_type = rec;
    r.want.data_addr_bits = bits;
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      fault_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function automatic void check_verdict(input out_beat_t got);
    out_beat_t want;
    if (verdicts_due.size() == 0) begin
      fault_count++;
      $display("%0t ns: verdict with none pending, expected nothing, %s %0d %s %0d %s %0d",
               $time, "got status", got.status, "type", got.record_type,
               "bits", got.data_addr_bits);
    end else begin
      want = verdicts_due.pop_front();
      check_field("status", 8'(want.status), 8'(got.status));
      check_field("record_type", 8'(want.record_type), 8'(got.record_type));
      check_field("data_addr_bits", 8'(want.data_addr_bits), 8'(got.data_addr_bits));
    end
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? CHAR_ZERO + n : CHAR_A + (n - 4'd10);
  endfunction

  function automatic int addr_bytes(input logic [3:0] rec);
    case (rec)
      REC_DATA24, REC_COUNT24, REC_START24: return 3;
      REC_DATA32, REC_START32:              return 4;
      default:                              return 2;
    endcase
  endfunction

  // Builds a well-formed record of the given type into line_text: count,
  // random address and data, and the one's complement checksum.
  function automatic void build_record(input logic [3:0] rec, input int data_len);
    logic [7:0] sum;
    logic [7:0] b;
    int         body;
    body = addr_bytes(rec) + data_len;
    line_text.delete();
    line_text.push_back(CHAR_S);
    line_text.push_back(CHAR_ZERO + rec);
    sum = 8'(body + 1);
    line_text.push_back(hex_char(sum[7:4]));
    line_text.push_back(hex_char(sum[3:0]));
    repeat (body) begin
      b = 8'($urandom_range(255));
      sum = sum + b;
      line_text.push_back(hex_char(b[7:4]));
      line_text.push_back(hex_char(b[3:0]));
    end
    b = ~sum;
    line_text.push_back(hex_char(b[7:4]));
    line_text.push_back(hex_char(b[3:0]));
  endfunction

  // Breaks a built record in one of several ways that a real file can go wrong.
  function automatic void mangle_line();
    int n;
    n = line_text.size();
    case ($urandom_range(8))
      0: line_text[$urandom_range(n - 1)] = 8'($urandom_range(255));
      1: void'(line_text.pop_back());
      2: line_text[$urandom_range(n - 1, 2)] = hex_char(4'($urandom_range(15)));
      3: begin
        line_text[2] = hex_char(4'($urandom_range(15)));
        line_text[3] = hex_char(4'($urandom_range(15)));
      end
      4: line_text[$urandom_range(n - 1, 2)] = 8'("a" + $urandom_range(5));
      5: begin
        n = $urandom_range(n - 1, 1);
        while (line_text.size() > n) void'(line_text.pop_back());
      end
      6: begin
        if ($urandom_range(1)) line_text[1] = 8'(CHAR_ZERO + $urandom_range(9));
        else line_text[0] = 8'($urandom_range(255));
      end
      7: begin
        line_text.push_back(hex_char(4'($urandom_range(15))));
        line_text.push_back(hex_char(4'($urandom_range(15))));
      end
      default: restart_at = $urandom_range(n - 1, 1);
    endcase
  endfunction

  // Offers one character beat, with random gaps, and holds it until taken.
  task automatic send_char(input in_beat_t b);
    while (char_gaps && $urandom_range(99) < 22) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_beat <= b;
    do @(posedge clk); while (char_stall);
  endtask

  // Sends line_text as one line and records the verdict it should produce.
  // A pending restart point raises file_start in the middle of the line.
  task automatic send_line(input bit opens_file);
    in_beat_t  b;
    out_beat_t v;
    for (int i = 0; i < line_text.size(); i++) begin
      b.ch = line_text[i];
      b.line_end = (i == line_text.size() - 1);
      b.file_start = (i == 0 && opens_file) || (i == restart_at);
      send_char(b);
      if (predict_verdict(b, v)) verdicts_due.push_back(v);
      if (i < SLC_MAX_LINE_CHARS) random_chars++;
    end
    restart_at = -1;
  endtask

  // Sender holds off until every verdict owed so far has been delivered.
  task automatic drain_verdicts();
    char_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
  endtask

  // Result side: checks every accepted verdict beat and drives the stall.
  // A hold request from the sender side turns into a long stall counted here.
  initial begin : verdict_side
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) check_verdict(result_beat);
      if (holds_served != hold_asks) begin
        holds_served = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= result_gaps && ($urandom_range(99) < 22);
      end
    end
  end

  // The run ends here if the block stops making progress.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    in_beat_t   b;
    out_beat_t  v;
    bit         got_one;
    bit         pause_done;
    bit         hold_done;
    bit         overlong_done;
    logic [3:0] data_rec;
    logic [3:0] rec;
    int         n;
    pause_done = 1'b0;
    hold_done = 1'b0;
    overlong_done = 1'b0;

    // Directed lines: a bare S0 header, a minimal good S1 as the second line,
    // a restart in mid-line whose single character cannot be a header, a
    // one-character second line, a reserved S4, and a line with a NUL and a
    // lower case hex digit. Character codes 0x00 and 0xFF both appear.
    drill_rows = '{
      drill_row("S",   1'b0, 1'b1, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b1, 1'b0, 1'b1, ST_BYTE_COUNT, REC_HEADER, 6'd0),
      drill_row("S",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("1",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("3",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("0",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("F",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("C",   1'b1, 1'b0, 1'b1, ST_OK,         REC_DATA16, 6'd16),
      drill_row("S",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("5",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("Q",   1'b1, 1'b1, 1'b1, ST_NO_HEADER,  4'd0,       6'd0),
      drill_row(8'hFF, 1'b1, 1'b0, 1'b1, ST_ODD_LENGTH, 4'd0,       6'd0),
      drill_row("S",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("4",   1'b1, 1'b0, 1'b1, ST_BAD_TYPE,   4'd4,       6'd0),
      drill_row("S",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("9",   1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row(8'h00, 1'b0, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0),
      drill_row("a",   1'b1, 1'b0, 1'b0, ST_OK,         4'd0,       6'd0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (drill_rows[i]) begin
      b = drill_rows[i].beat;
      send_char(b);
      got_one = predict_verdict(b, v);
      if (drill_rows[i].typed) verdicts_due.push_back(drill_rows[i].want);
      else if (got_one) verdicts_due.push_back(v);
    end
    drain_verdicts();

    // Random part: mostly whole files of well-formed records with random
    // content, some of them corrupted, and a little raw noise in between.
    while (random_chars < RANDOM_CHARS) begin
      // A long middle stretch runs with neither side idling.
      char_gaps = !(random_chars >= 600 && random_chars < 1100);
      result_gaps = char_gaps;
      if (!pause_done && random_chars >= 900) begin
        pause_done = 1'b1;
        drain_verdicts();
      end
      if (!hold_done && random_chars >= 1300) begin
        hold_done = 1'b1;
        hold_asks++;
      end
      if (!overlong_done && random_chars >= 1500) begin
        // Maximum byte count, then padding well past the character limit.
        overlong_done = 1'b1;
        build_record(REC_DATA32, 250);
        while (line_text.size() < 1100) line_text.push_back(hex_char(4'($urandom_range(15))));
        send_line(1'b0);
      end

      if ($urandom_range(99) < 8) begin
        line_text.delete();
        n = $urandom_range(12, 1);
        repeat (n) line_text.push_back(8'($urandom_range(255)));
        send_line($urandom_range(2) == 0);
      end else begin
        data_rec = 4'($urandom_range(3, 1));

        build_record(REC_HEADER, $urandom_range(8));
        if ($urandom_range(99) < 15) mangle_line();
        send_line($urandom_range(9) != 0);

        // The second line fixes the address width; now and then it is not data.
        rec = ($urandom_range(99) < 85) ? data_rec : 4'($urandom_range(9));
        build_record(rec, (rec >= REC_COUNT16 || rec == REC_HEADER) ? 0 : $urandom_range(8));
        if ($urandom_range(99) < 15) mangle_line();
        send_line(1'b0);

        repeat ($urandom_range(6)) begin
          n = $urandom_range(99);
          if (n < 8) build_record(($urandom_range(1) != 0) ? REC_COUNT16 : REC_COUNT24, 0);
          else if (n < 10) build_record(data_rec, 254 - addr_bytes(data_rec));
          else build_record(data_rec, $urandom_range(16));
          if ($urandom_range(99) < 20) mangle_line();
          send_line(1'b0);
        end

        // Termination record that matches the data width: S9, S8 or S7.
        build_record(REC_START16 + REC_DATA16 - data_rec, 0);
        if ($urandom_range(99) < 20) mangle_line();
        send_line(1'b0);
      end
    end

    char_valid <= 1'b0;
    do @(posedge clk); while (verdicts_due.size() != 0);
    repeat (SETTLE) @(posedge clk);

    if (fault_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
